/* hw/rtl/ihfs_pkg.sv */
// ----------------------------------------------------------------------------
// ihfs_pkg
// Shared constants, format codes and types of the image header sniffer.
// ----------------------------------------------------------------------------
`default_nettype none

package ihfs_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned FileSizeW = 31;
  localparam int unsigned CodeW     = 3;
  localparam int unsigned HdrKeep   = 18;
  localparam int unsigned HdrMin    = 12;
  localparam int unsigned CountW    = 5;
  localparam logic [CountW-1:0] CountMax = 5'd31;

  localparam logic [CodeW-1:0] CodeUnknown = 3'd0;
  localparam logic [CodeW-1:0] CodePng     = 3'd1;
  localparam logic [CodeW-1:0] CodeJpeg    = 3'd2;
  localparam logic [CodeW-1:0] CodeTga     = 3'd3;
  localparam logic [CodeW-1:0] CodePatch   = 3'd4;
  localparam logic [CodeW-1:0] CodeOther   = 3'd5;

  localparam logic [ByteW-1:0] PngMagic    = 8'h89;
  localparam logic [ByteW-1:0] JpegMarker  = 8'hFF;
  localparam logic [ByteW-1:0] JpegSoi     = 8'hD8;
  localparam logic [ByteW-1:0] JpegAppMin  = 8'hE0;
  localparam logic [ByteW-1:0] DdsHdrSize  = 8'd124;

  localparam logic [15:0] TgaMaxDim      = 16'd2048;
  localparam logic [15:0] PatchMaxWidth  = 16'd4096;
  localparam logic [15:0] PatchMaxHeight = 16'd1024;
  localparam logic signed [15:0] PatchMaxOfs = 16'sd4096;

  typedef logic [HdrKeep-1:0][ByteW-1:0] hdr_bytes_t;

  typedef struct packed {
    logic long_enough;
    logic full;
  } len_flags_t;

endpackage

`default_nettype wire

/* hw/rtl/ihfs_in_if.sv */
// ----------------------------------------------------------------------------
// ihfs_in_if
// Header byte channel: one byte of the file header per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ihfs_in_if;
  import ihfs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ByteW-1:0]     header_byte;
  logic                 last_byte;
  logic [FileSizeW-1:0] file_len;

  modport source (output valid, output header_byte, output last_byte, output file_len,
                  input ready);
  modport sink (input valid, input header_byte, input last_byte, input file_len,
                output ready);
endinterface

`default_nettype wire

/* hw/rtl/ihfs_out_if.sv */
// ----------------------------------------------------------------------------
// ihfs_out_if
// Result channel: one format code per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ihfs_out_if;
  import ihfs_pkg::*;

  logic             valid;
  logic             ready;
  logic [CodeW-1:0] format_code;

  modport source (output valid, output format_code, input ready);
  modport sink (input valid, input format_code, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ihfs_capture.sv */
// ----------------------------------------------------------------------------
// ihfs_capture
// Keeps the first header bytes and a saturating byte count; presents the
// header as it stands including the byte being accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module ihfs_capture (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            accept_i,
  input  wire logic [ihfs_pkg::ByteW-1:0]      byte_i,
  input  wire logic                            last_i,
  output ihfs_pkg::hdr_bytes_t                 hdr_o,
  output ihfs_pkg::len_flags_t                 len_o
);
  import ihfs_pkg::*;

  logic [CountW-1:0] count_q, count_d;
  hdr_bytes_t        store_q;

  always_comb begin
    count_d = count_q;
    if (accept_i) begin
      if (last_i) begin
        count_d = '0;
      end else if (count_q != CountMax) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  for (genvar i = 0; i < HdrKeep; i++) begin : g_entry
    always_ff @(posedge clk_i) begin
      if (accept_i && (count_q == CountW'(i))) begin
        store_q[i] <= byte_i;
      end
    end
    assign hdr_o[i] = (count_q == CountW'(i)) ? byte_i : store_q[i];
  end

  // count includes the byte being accepted
  assign len_o.long_enough = (count_q >= CountW'(HdrMin - 1));
  assign len_o.full        = (count_q >= CountW'(HdrKeep - 1));

`ifndef NO_ASSERTIONS
  a_count_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |=> count_q == '0)
    else $error("byte count not cleared after final byte");

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !last_i && count_q != CountMax |=> count_q == $past(count_q) + 1'b1)
    else $error("byte count did not advance");

  a_count_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(count_q))
    else $error("byte count moved without an item");
`endif

endmodule

`default_nettype wire

/* hw/rtl/ihfs_classify.sv */
// ----------------------------------------------------------------------------
// ihfs_classify
// Format decision from the header bytes, the byte count and the file size.
// ----------------------------------------------------------------------------
`default_nettype none

module ihfs_classify (
  input  wire ihfs_pkg::hdr_bytes_t            hdr_i,
  input  wire ihfs_pkg::len_flags_t            len_i,
  input  wire logic [ihfs_pkg::FileSizeW-1:0]  file_len_i,
  output logic [ihfs_pkg::CodeW-1:0]           code_o
);
  import ihfs_pkg::*;

  logic              is_png, is_jpeg, is_gif, is_dds, is_tga, is_patch;
  logic [15:0]       tga_w, tga_h, pat_w, pat_h;
  logic [ByteW-1:0]  tga_it, tga_d;
  logic signed [15:0] pat_ox, pat_oy;
  logic [FileSizeW-1:0] pat_min_size;

  assign is_png = (hdr_i[0] == PngMagic) && (hdr_i[1] == "P") && (hdr_i[2] == "N")
               && (hdr_i[3] == "G") && (hdr_i[4] == 8'h0D) && (hdr_i[5] == 8'h0A);

  assign is_jpeg = (hdr_i[0] == JpegMarker) && (hdr_i[1] == JpegSoi)
                && (hdr_i[2] == JpegMarker) && (hdr_i[3] >= JpegAppMin)
                && (((hdr_i[6] == "J") && (hdr_i[7] == "F"))
                 || ((hdr_i[6] == "E") && (hdr_i[7] == "x")));

  assign is_gif = (hdr_i[0] == "G") && (hdr_i[1] == "I") && (hdr_i[2] == "F")
               && (hdr_i[3] == "8") && (hdr_i[4] >= "7") && (hdr_i[4] <= "9")
               && (hdr_i[5] == "a");

  assign is_dds = (hdr_i[0] == "D") && (hdr_i[1] == "D") && (hdr_i[2] == "S")
               && (hdr_i[3] == 8'h20) && (hdr_i[4] == DdsHdrSize)
               && (hdr_i[5] == 8'h00) && (hdr_i[6] == 8'h00);

  assign tga_w  = {hdr_i[13], hdr_i[12]};
  assign tga_h  = {hdr_i[15], hdr_i[14]};
  assign tga_it = hdr_i[2] | 8'h08;
  assign tga_d  = hdr_i[16];

  assign is_tga = len_i.full
               && (tga_w != '0) && (tga_w <= TgaMaxDim)
               && (tga_h != '0) && (tga_h <= TgaMaxDim)
               && (hdr_i[1] <= 8'd1)
               && (tga_it <= 8'd11)
               && ((tga_d == 8'd8) || (tga_d == 8'd15) || (tga_d == 8'd16)
                || (tga_d == 8'd24) || (tga_d == 8'd32));

  assign pat_w  = {hdr_i[1], hdr_i[0]};
  assign pat_h  = {hdr_i[3], hdr_i[2]};
  assign pat_ox = {hdr_i[5], hdr_i[4]};
  assign pat_oy = {hdr_i[7], hdr_i[6]};
  assign pat_min_size = {{(FileSizeW-18){1'b0}}, pat_w, 2'b00};

  assign is_patch = (pat_w != '0) && (pat_w <= PatchMaxWidth)
                 && (pat_h != '0) && (pat_h <= PatchMaxHeight)
                 && (pat_ox >= -PatchMaxOfs) && (pat_ox <= PatchMaxOfs)
                 && (pat_oy >= -PatchMaxOfs) && (pat_oy <= PatchMaxOfs)
                 && (file_len_i > pat_min_size);

  always_comb begin
    if (!len_i.long_enough) begin
      code_o = CodeUnknown;
    end else if (is_png) begin
      code_o = CodePng;
    end else if (is_jpeg) begin
      code_o = CodeJpeg;
    end else if (is_gif || is_dds) begin
      code_o = CodeOther;
    end else if (is_tga) begin
      code_o = CodeTga;
    end else if (is_patch) begin
      code_o = CodePatch;
    end else begin
      code_o = CodeUnknown;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ihfs_out_reg.sv */
// ----------------------------------------------------------------------------
// ihfs_out_reg
// Result register holding one format code until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ihfs_out_reg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        load_i,
  input  wire logic [ihfs_pkg::CodeW-1:0]  code_i,
  input  wire logic                        ready_i,
  output logic                             valid_o,
  output logic [ihfs_pkg::CodeW-1:0]       code_o
);
  import ihfs_pkg::*;

  logic             valid_q, valid_d;
  logic [CodeW-1:0] code_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      code_q <= code_i;
    end
  end

  assign valid_o = valid_q;
  assign code_o  = code_q;

endmodule

`default_nettype wire

/* hw/rtl/image_header_format_sniffer_top.sv */
// ----------------------------------------------------------------------------
// image_header_format_sniffer_top
// Image format detection from the leading bytes of a file.
// ----------------------------------------------------------------------------
// Takes one header byte per cycle, with no gaps needed between files. The
// format code of a file appears on the result channel in the cycle after its
// final byte is accepted and is held in a single output register until
// taken; the byte channel stalls only while that register is full and not
// being drained. The decision is made in the cycle the final byte arrives,
// from the first eighteen stored bytes, the byte count and the file size.
// ----------------------------------------------------------------------------
`default_nettype none

module image_header_format_sniffer_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ihfs_in_if.sink     in_i,
  ihfs_out_if.source  out_o
);
  import ihfs_pkg::*;

  logic             in_ready;
  logic             in_accept;
  logic             out_valid;
  logic             load;
  logic [CodeW-1:0] code;
  logic [CodeW-1:0] out_code;
  hdr_bytes_t       hdr;
  len_flags_t       len_flags;

  assign in_ready  = !out_valid || out_o.ready;
  assign in_accept = in_i.valid && in_ready;
  assign load      = in_accept && in_i.last_byte;

  assign in_i.ready = in_ready;

  ihfs_capture u_capture (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .byte_i   (in_i.header_byte),
    .last_i   (in_i.last_byte),
    .hdr_o    (hdr),
    .len_o    (len_flags)
  );

  ihfs_classify u_classify (
    .hdr_i      (hdr),
    .len_i      (len_flags),
    .file_len_i (in_i.file_len),
    .code_o     (code)
  );

  ihfs_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .code_i  (code),
    .ready_i (out_o.ready),
    .valid_o (out_valid),
    .code_o  (out_code)
  );

  assign out_o.valid       = out_valid;
  assign out_o.format_code = out_code;

`ifndef NO_ASSERTIONS
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid)
    else $error("final byte gave no result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_o.ready |-> !in_ready)
    else $error("input open while a result is stalled");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_code <= CodeOther)
    else $error("format code out of range");
`endif

endmodule

`default_nettype wire
